// ===== hw/rtl/jhp_pkg.sv =====
// ----------------------------------------------------------------------------
// jhp_pkg
// Shared types, status codes and helpers for the JPEG header probe.
// ----------------------------------------------------------------------------
package jhp_pkg;

    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned DIM_W      = 16;
    localparam int unsigned COMP_W     = 8;
    localparam int unsigned DPI_W      = 24;
    localparam int unsigned RESULT_W   = STATUS_W + 2 * DIM_W + COMP_W + 2 * DPI_W;
    localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SOI     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SOF    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_COMP   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 3'd7;

    typedef struct packed {
        logic [DPI_W-1:0]    dpi_y_centi;
        logic [DPI_W-1:0]    dpi_x_centi;
        logic [COMP_W-1:0]   component_count;
        logic [DIM_W-1:0]    image_height;
        logic [DIM_W-1:0]    image_width;
        logic [STATUS_W-1:0] status;
    } t_result;

    // expected "JFIF\0" tag byte at a tag position
    function automatic logic [7:0] jfif_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                3'd0:    c = 8'h4A;
                3'd1:    c = 8'h46;
                3'd2:    c = 8'h49;
                3'd3:    c = 8'h46;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // per-inch x100 by shift and add, per-cm x254 by shift and subtract
    function automatic logic [DPI_W-1:0] to_centi(input logic [DIM_W-1:0] raw,
                                                   input logic per_inch);
        logic [DPI_W-1:0] w;
        begin
            w = {8'd0, raw};
            if (per_inch) begin
                return (w << 6) + (w << 5) + (w << 2);
            end else begin
                return (w << 8) - (w << 1);
            end
        end
    endfunction

endpackage

// ===== hw/rtl/jhp_parser.sv =====
// ----------------------------------------------------------------------------
// jhp_parser
// Marker and segment parser state; one file byte per take, result on end.
// ----------------------------------------------------------------------------
module jhp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  logic             i_last,
    output logic             o_res_vld,
    output jhp_pkg::t_result o_res
);

    localparam logic [3:0] PH_SOI0  = 4'd0;
    localparam logic [3:0] PH_SOI1  = 4'd1;
    localparam logic [3:0] PH_SEEK  = 4'd2;
    localparam logic [3:0] PH_MARK  = 4'd3;
    localparam logic [3:0] PH_LENHI = 4'd4;
    localparam logic [3:0] PH_LENLO = 4'd5;
    localparam logic [3:0] PH_SOF   = 4'd6;
    localparam logic [3:0] PH_APP0  = 4'd7;
    localparam logic [3:0] PH_SKIP  = 4'd8;

    logic [3:0]  r_phase, c_phase, n_phase;
    logic [15:0] r_seg,   c_seg,   n_seg;
    logic [15:0] r_skip,  c_skip,  n_skip;
    logic [7:0]  r_mark,  c_mark,  n_mark;
    logic [3:0]  r_pos,   c_pos,   n_pos;
    logic [7:0]  r_hold,  c_hold,  n_hold;
    logic        r_tag,   c_tag,   n_tag;
    logic [7:0]  r_units, c_units, n_units;
    logic [15:0] r_rawx,  c_rawx,  n_rawx;
    logic [15:0] r_wid,   c_wid,   n_wid;
    logic [15:0] r_hgt,   c_hgt,   n_hgt;
    logic [7:0]  r_comp,  c_comp,  n_comp;
    logic [23:0] r_dpix,  c_dpix,  n_dpix;
    logic [23:0] r_dpiy,  c_dpiy,  n_dpiy;
    logic        r_fin,   c_fin,   n_fin;

    logic                          st_vld;
    logic [jhp_pkg::STATUS_W-1:0]  st;
    logic [15:0]                   word;
    logic [15:0]                   len_m2;
    logic                          is_sof;

    // a first byte restarts from the reset state
    always_comb begin
        if (i_first) begin
            c_phase = PH_SOI0; c_seg = '0; c_skip = '0; c_mark = '0; c_pos = '0;
            c_hold = '0; c_tag = 1'b1; c_units = '0; c_rawx = '0; c_wid = '0;
            c_hgt = '0; c_comp = '0; c_dpix = '0; c_dpiy = '0; c_fin = 1'b0;
        end else begin
            c_phase = r_phase; c_seg = r_seg; c_skip = r_skip; c_mark = r_mark;
            c_pos = r_pos; c_hold = r_hold; c_tag = r_tag; c_units = r_units;
            c_rawx = r_rawx; c_wid = r_wid; c_hgt = r_hgt; c_comp = r_comp;
            c_dpix = r_dpix; c_dpiy = r_dpiy; c_fin = r_fin;
        end
    end

    assign word   = {c_hold, i_byte};
    assign len_m2 = word - 16'd2;
    assign is_sof = (c_mark[7:4] == 4'hC) && (c_mark != 8'hC4) && (c_mark != 8'hC8)
                    && (c_mark != 8'hCC);

    always_comb begin
        n_phase = c_phase; n_seg = c_seg; n_skip = c_skip; n_mark = c_mark;
        n_pos = c_pos; n_hold = c_hold; n_tag = c_tag; n_units = c_units;
        n_rawx = c_rawx; n_wid = c_wid; n_hgt = c_hgt; n_comp = c_comp;
        n_dpix = c_dpix; n_dpiy = c_dpiy;
        st_vld = 1'b0;
        st     = jhp_pkg::ST_OK;
        if (!c_fin) begin
            unique case (c_phase)
                PH_SOI0: begin
                    if (i_byte == 8'hFF) n_phase = PH_SOI1;
                    else begin st_vld = 1'b1; st = jhp_pkg::ST_NO_SOI; end
                end
                PH_SOI1: begin
                    if (i_byte == 8'hD8) n_phase = PH_SEEK;
                    else begin st_vld = 1'b1; st = jhp_pkg::ST_NO_SOI; end
                end
                PH_SEEK: begin
                    if (i_byte == 8'hFF) n_phase = PH_MARK;
                end
                PH_MARK: begin
                    if (i_byte != 8'hFF) begin
                        n_mark = i_byte;
                        if (i_byte == 8'hD8 || i_byte == 8'hD9 || i_byte[7:3] == 5'b11010) begin
                            n_phase = PH_SEEK;
                        end else if (i_byte == 8'hDA) begin
                            st_vld = 1'b1;
                            st = (c_wid == 16'd0) ? jhp_pkg::ST_NO_FRAME : jhp_pkg::ST_OK;
                        end else begin
                            n_phase = PH_LENHI;
                        end
                    end
                end
                PH_LENHI: begin
                    n_hold  = i_byte;
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_seg = word;
                    if (word < 16'd2) begin
                        st_vld = 1'b1; st = jhp_pkg::ST_BAD_LEN;
                    end else if (is_sof) begin
                        if (c_mark != 8'hC0 && c_mark != 8'hC1) begin
                            st_vld = 1'b1; st = jhp_pkg::ST_BAD_SOF;
                        end else begin
                            n_pos = '0; n_phase = PH_SOF;
                        end
                    end else if (c_mark == 8'hE0 && word >= 16'd16) begin
                        n_pos = '0; n_tag = 1'b1; n_phase = PH_APP0;
                    end else begin
                        n_skip  = len_m2;
                        n_phase = (len_m2 == 16'd0) ? PH_SEEK : PH_SKIP;
                    end
                end
                PH_SOF: begin
                    case (c_pos)
                        4'd1, 4'd3: n_hold = i_byte;
                        4'd2:       n_hgt  = word;
                        4'd4:       n_wid  = word;
                        4'd5: begin
                            n_comp = i_byte;
                            st_vld = 1'b1;
                            if (c_wid == 16'd0 || c_hgt == 16'd0) st = jhp_pkg::ST_ZERO_SIZE;
                            else if (i_byte != 8'd1 && i_byte != 8'd3 && i_byte != 8'd4)
                                st = jhp_pkg::ST_BAD_COMP;
                            else st = jhp_pkg::ST_OK;
                        end
                        default: ;
                    endcase
                    n_pos = c_pos + 4'd1;
                end
                PH_APP0: begin
                    if (c_pos < 4'd5) begin
                        if (i_byte != jhp_pkg::jfif_char(c_pos[2:0])) n_tag = 1'b0;
                    end else if (c_pos == 4'd7) begin
                        n_units = i_byte;
                    end else if (c_pos == 4'd8 || c_pos == 4'd10) begin
                        n_hold = i_byte;
                    end else if (c_pos == 4'd9) begin
                        n_rawx = word;
                    end else if (c_pos == 4'd11) begin
                        if (c_tag && (c_units == 8'd1 || c_units == 8'd2)) begin
                            n_dpix = jhp_pkg::to_centi(c_rawx, c_units[0]);
                            n_dpiy = jhp_pkg::to_centi(word, c_units[0]);
                        end
                    end
                    if (c_pos >= 4'd13) begin
                        n_pos   = '0;
                        n_skip  = c_seg - 16'd16;
                        n_phase = (c_seg == 16'd16) ? PH_SEEK : PH_SKIP;
                    end else begin
                        n_pos = c_pos + 4'd1;
                    end
                end
                PH_SKIP: begin
                    n_skip = c_skip - 16'd1;
                    if (c_skip == 16'd1) n_phase = PH_SEEK;
                end
                default: n_phase = PH_SOI0;
            endcase
            if (!st_vld && i_last) begin
                st_vld = 1'b1; st = jhp_pkg::ST_TRUNCATED;
            end
        end
        n_fin = c_fin | st_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI0; r_seg <= '0; r_skip <= '0; r_mark <= '0; r_pos <= '0;
            r_hold <= '0; r_tag <= 1'b1; r_units <= '0; r_rawx <= '0; r_wid <= '0;
            r_hgt <= '0; r_comp <= '0; r_dpix <= '0; r_dpiy <= '0; r_fin <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_seg <= n_seg; r_skip <= n_skip; r_mark <= n_mark;
            r_pos <= n_pos; r_hold <= n_hold; r_tag <= n_tag; r_units <= n_units;
            r_rawx <= n_rawx; r_wid <= n_wid; r_hgt <= n_hgt; r_comp <= n_comp;
            r_dpix <= n_dpix; r_dpiy <= n_dpiy; r_fin <= n_fin;
        end
    end

    assign o_res_vld             = i_take && st_vld;
    assign o_res.status          = st;
    assign o_res.image_width     = n_wid;
    assign o_res.image_height    = n_hgt;
    assign o_res.component_count = n_comp;
    assign o_res.dpi_x_centi     = n_dpix;
    assign o_res.dpi_y_centi     = n_dpiy;

endmodule

// ===== hw/rtl/jhp_out_reg.sv =====
// ----------------------------------------------------------------------------
// jhp_out_reg
// Result register holding one parse result until the receiver takes it.
// ----------------------------------------------------------------------------
module jhp_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  jhp_pkg::t_result                  i_res,
    output logic                              o_free,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [jhp_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    logic             r_vld;
    jhp_pkg::t_result r_res;

    assign o_free = !r_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_vld;
    assign o_m_axis_tdata  = {{(jhp_pkg::OUT_DATA_W - jhp_pkg::RESULT_W){1'b0}}, r_res};

endmodule

// ===== hw/rtl/jpeg_header_probe_top.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_probe_top
// JPEG header probe: walks the marker segments of a byte stream and reports
// status, frame geometry and pixel density in one result per file.
// ----------------------------------------------------------------------------
// usage
//   input stream: one file byte per request on tdata, tuser = first byte of a
//   file (restarts parsing), tlast = final byte of the file.
//   output stream: one result per file when parsing ends (SOS, frame header
//   done, error or last byte); bytes after that are taken and dropped until
//   the next first byte.
//   path: a byte is registered in the input register, is parsed as it
//   leaves it, and its result is registered in the output register.
//   throughput: one byte per cycle while the result register is free; the
//   per-byte state update is the only loop.
//   reset: synchronous, clears both registers and the parser to wait for SOI.
//   stall: while a result waits, the input register still fills; the parser
//   holds its byte until the result register is free, then input backs up.
// ----------------------------------------------------------------------------
module jpeg_header_probe_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tuser,  // [0] first_of_file
    input  logic                           i_s_axis_tlast,  // last_of_file
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [2:0] status, [18:3] image_width, [34:19] image_height,
    // [42:35] component_count, [66:43] dpi_x_centi, [90:67] dpi_y_centi
    output logic [jhp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_first;
    logic             r_in_last;
    logic             w_out_free;
    logic             w_take;
    logic             w_res_vld;
    jhp_pkg::t_result w_res;

    assign w_take          = r_in_vld && w_out_free;
    assign o_s_axis_tready = !r_in_vld || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser;
            r_in_last  <= i_s_axis_tlast;
        end
    end

    jhp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (r_in_byte),
        .i_first   (r_in_first),
        .i_last    (r_in_last),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    jhp_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_res_vld),
        .i_res           (w_res),
        .o_free          (w_out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_res_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result produced while result register busy");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_take) |=> (r_in_vld && $stable(r_in_byte) && $stable(r_in_first)
                                   && $stable(r_in_last)))
        else $error("input register changed before the parser took it");

    a_ok_geometry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && w_res.status == jhp_pkg::ST_OK) |->
        (w_res.image_width != 16'd0 && w_res.image_height != 16'd0 &&
         (w_res.component_count == 8'd1 || w_res.component_count == 8'd3 ||
          w_res.component_count == 8'd4)))
        else $error("ok status without a valid frame header");
`endif

endmodule
